// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the overlap test block. All checks use the
// clock clk of the including module, and SAOT_ASSERT also its active-low reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SAOT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SAOT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAOT_ASSERT(label, prop, msg)
`define SAOT_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: hw/rtl/saot_pkg.sv
// Package of the separating-axis overlap test: value types, operation codes,
// the pipeline control bundle and the saturating adders. Depends on nothing.
package saot_pkg;

    localparam int COORD_FIELD_W = 32;
    localparam int RADIUS_W      = 31;
    localparam int RADIUS_SHIFT  = 16;
    localparam int LANES         = 3;

    localparam logic [1:0] OP_SPHERE_BOX    = 2'd1;
    localparam logic [1:0] OP_SPHERE_SPHERE = 2'd2;

    typedef logic signed [63:0] sval_t;
    typedef logic [63:0]        uval_t;

    typedef struct packed {
        logic ld_p1;
        logic ld_p2;
        logic ld_p3;
        logic ld_p4;
        logic ld_p5;
        logic ld_out;
        logic v_p5;
    } saot_pipe_t;

    function automatic sval_t sat_add(input sval_t a, input sval_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            sat_add = s[63:0];
        end
    endfunction

    function automatic uval_t usat_add(input uval_t a, input uval_t b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        usat_add = s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

// File: hw/rtl/saot_lane.sv
// One coordinate lane: the axis products of both points and the squared
// centre difference, over two register stages. Depends on saot_pkg.
module saot_lane
    import saot_pkg::*;
#(
    parameter int CW = 32
)
(
    input  logic                     clk,
    input  saot_pipe_t               pipe,
    input  logic [COORD_FIELD_W-1:0] axis,
    input  logic [COORD_FIELD_W-1:0] p,
    input  logic [COORD_FIELD_W-1:0] q,
    output sval_t                    ap,
    output sval_t                    aq,
    output uval_t                    dd
);

    logic signed [CW-1:0]   a_c;
    logic signed [CW-1:0]   p_c;
    logic signed [CW-1:0]   q_c;
    logic signed [CW:0]     diff;
    logic signed [CW:0]     diff_neg;
    logic [CW-1:0]          mag1_next;
    logic signed [2*CW-1:0] ap_full;
    logic signed [2*CW-1:0] aq_full;
    logic [2*CW-1:0]        dd_full;
    sval_t                  ap1_next;
    sval_t                  aq1_next;
    uval_t                  dd2_next;
    sval_t                  ap1_reg;
    sval_t                  aq1_reg;
    logic [CW-1:0]          mag1_reg;
    sval_t                  ap2_reg;
    sval_t                  aq2_reg;
    uval_t                  dd2_reg;

    assign a_c = signed'(axis[CW-1:0]);
    assign p_c = signed'(p[CW-1:0]);
    assign q_c = signed'(q[CW-1:0]);

    assign diff      = (CW+1)'(p_c) - (CW+1)'(q_c);
    assign diff_neg  = -diff;
    assign mag1_next = diff[CW] ? diff_neg[CW-1:0] : diff[CW-1:0];

    assign ap_full  = a_c * p_c;
    assign aq_full  = a_c * q_c;
    assign ap1_next = 64'(ap_full);
    assign aq1_next = 64'(aq_full);

    assign dd_full  = mag1_reg * mag1_reg;
    assign dd2_next = 64'(dd_full);

    always_ff @(posedge clk)
    begin
        if (pipe.ld_p1)
        begin
            ap1_reg  <= ap1_next;
            aq1_reg  <= aq1_next;
            mag1_reg <= mag1_next;
        end
        if (pipe.ld_p2)
        begin
            ap2_reg <= ap1_reg;
            aq2_reg <= aq1_reg;
            dd2_reg <= dd2_next;
        end
    end

    assign ap = ap2_reg;
    assign aq = aq2_reg;
    assign dd = dd2_reg;

endmodule

// File: hw/rtl/saot_merge.sv
// Merging stages: saturating sums of the lane results, sphere widening, the
// running interval bounds and the overlap decision. Depends on saot_pkg.
module saot_merge
    import saot_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  saot_pipe_t    pipe,
    input  sval_t         ap [LANES],
    input  sval_t         aq [LANES],
    input  uval_t         dd [LANES],
    input  logic [1:0]    op,
    input  logic          last,
    input  logic [RADIUS_W-1:0] radius,
    input  uval_t         r2,
    output logic          p5_last,
    output logic          overlap
);

    sval_t               sp3_reg, sq3_reg, ap3_reg, aq3_reg;
    uval_t               d3_reg, dd3_reg, r23_reg;
    logic [1:0]          op3_reg;
    logic                last3_reg;
    logic [RADIUS_W-1:0] rad3_reg;

    sval_t               pp4_reg, qq4_reg, rs4_reg, rs4_next;
    uval_t               d4_reg, r24_reg;
    logic [1:0]          op4_reg;
    logic                last4_reg;

    sval_t               lo5_reg, hi5_reg, qq5_reg, lo5_next, hi5_next;
    logic                hit5_reg;
    logic [1:0]          op5_reg;
    logic                last5_reg;

    sval_t               first_min_reg, first_max_reg, second_min_reg, second_max_reg;
    sval_t               first_min_next, first_max_next, second_min_next, second_max_next;
    logic                expect_first_reg, expect_first_next;
    logic                overlap_reg, overlap_next;
    logic                commit;
    logic                is_sphere_pair;

    assign rs4_next = sval_t'(64'(rad3_reg) << RADIUS_SHIFT);

    always_comb
    begin
        if (op4_reg == OP_SPHERE_BOX)
        begin
            lo5_next = sat_add(pp4_reg, -rs4_reg);
            hi5_next = sat_add(pp4_reg, rs4_reg);
        end
        else
        begin
            lo5_next = pp4_reg;
            hi5_next = pp4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe.ld_p3)
        begin
            sp3_reg   <= sat_add(ap[0], ap[1]);
            sq3_reg   <= sat_add(aq[0], aq[1]);
            d3_reg    <= usat_add(dd[0], dd[1]);
            ap3_reg   <= ap[2];
            aq3_reg   <= aq[2];
            dd3_reg   <= dd[2];
            r23_reg   <= r2;
            op3_reg   <= op;
            last3_reg <= last;
            rad3_reg  <= radius;
        end
        if (pipe.ld_p4)
        begin
            pp4_reg   <= sat_add(sp3_reg, ap3_reg);
            qq4_reg   <= sat_add(sq3_reg, aq3_reg);
            d4_reg    <= usat_add(d3_reg, dd3_reg);
            rs4_reg   <= rs4_next;
            r24_reg   <= r23_reg;
            op4_reg   <= op3_reg;
            last4_reg <= last3_reg;
        end
        if (pipe.ld_p5)
        begin
            lo5_reg   <= lo5_next;
            hi5_reg   <= hi5_next;
            qq5_reg   <= qq4_reg;
            hit5_reg  <= d4_reg < r24_reg;
            op5_reg   <= op4_reg;
            last5_reg <= last4_reg;
        end
    end

    assign is_sphere_pair = op5_reg == OP_SPHERE_SPHERE;
    assign commit         = pipe.ld_out && pipe.v_p5;

    always_comb
    begin
        if (expect_first_reg)
        begin
            first_min_next  = lo5_reg;
            first_max_next  = hi5_reg;
            second_min_next = qq5_reg;
            second_max_next = qq5_reg;
        end
        else
        begin
            first_min_next  = (lo5_reg < first_min_reg) ? lo5_reg : first_min_reg;
            first_max_next  = (hi5_reg > first_max_reg) ? hi5_reg : first_max_reg;
            second_min_next = (qq5_reg < second_min_reg) ? qq5_reg : second_min_reg;
            second_max_next = (qq5_reg > second_max_reg) ? qq5_reg : second_max_reg;
        end

        if (is_sphere_pair)
        begin
            overlap_next      = hit5_reg;
            expect_first_next = expect_first_reg || last5_reg;
        end
        else
        begin
            overlap_next      = !(first_max_next < second_min_next ||
                                  second_max_next < first_min_next);
            expect_first_next = last5_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_first_reg <= 1'b1;
        end
        else if (commit)
        begin
            expect_first_reg <= expect_first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && !is_sphere_pair)
        begin
            first_min_reg  <= first_min_next;
            first_max_reg  <= first_max_next;
            second_min_reg <= second_min_next;
            second_max_reg <= second_max_next;
        end
        if (commit && last5_reg)
        begin
            overlap_reg <= overlap_next;
        end
    end

    assign p5_last = last5_reg;
    assign overlap = overlap_reg;

endmodule

// File: hw/rtl/sat_axis_overlap_test.sv
// Top level of the separating-axis overlap test: handshake control, the three
// coordinate lanes and the merging stages. Depends on saot_pkg, saot_lane,
// saot_merge and assert_macros.svh.
//
//  Channel   Handshake                    Payload
//  item      item_valid / item_ready      op, axis_*, p_*, q_*, radius, last
//  result    result_valid / result_ready  overlap
//
// One transaction is accepted per cycle while the pipeline moves.
// The last transaction of a test passes the two lane stages, three saturating merge
// stages and the output register before its result appears.
// After reset the block is ready at once; the interval bounds need no clearing.
// A stalled result holds the pipeline only once every stage is occupied, so
// item_ready falls only when all five stages and the output register are full.
`include "assert_macros.svh"

module sat_axis_overlap_test
    import saot_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [1:0]          op,
    input  logic signed [31:0]  axis_x,
    input  logic signed [31:0]  axis_y,
    input  logic signed [31:0]  axis_z,
    input  logic signed [31:0]  p_x,
    input  logic signed [31:0]  p_y,
    input  logic signed [31:0]  p_z,
    input  logic signed [31:0]  q_x,
    input  logic signed [31:0]  q_y,
    input  logic signed [31:0]  q_z,
    input  logic [RADIUS_W-1:0] radius,
    input  logic                last,
    output logic                result_valid,
    input  logic                result_ready,
    output logic                overlap
);

    logic [COORD_FIELD_W-1:0] axis_l [LANES];
    logic [COORD_FIELD_W-1:0] p_l [LANES];
    logic [COORD_FIELD_W-1:0] q_l [LANES];
    sval_t                    ap [LANES];
    sval_t                    aq [LANES];
    uval_t                    dd [LANES];

    saot_pipe_t               pipe;
    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                     result_valid_reg, result_valid_next;
    logic                     p5_last;

    logic [1:0]               op1_reg, op2_reg;
    logic                     last1_reg, last2_reg;
    logic [RADIUS_W-1:0]      rad1_reg, rad2_reg;
    logic [2*RADIUS_W-1:0]    r2_full;
    uval_t                    r2_reg, r2_next;

    assign axis_l[0] = axis_x;
    assign axis_l[1] = axis_y;
    assign axis_l[2] = axis_z;
    assign p_l[0]    = p_x;
    assign p_l[1]    = p_y;
    assign p_l[2]    = p_z;
    assign q_l[0]    = q_x;
    assign q_l[1]    = q_y;
    assign q_l[2]    = q_z;

    assign pipe.ld_out = !result_valid_reg || result_ready;
    assign pipe.ld_p5  = !v5_reg || pipe.ld_out;
    assign pipe.ld_p4  = !v4_reg || pipe.ld_p5;
    assign pipe.ld_p3  = !v3_reg || pipe.ld_p4;
    assign pipe.ld_p2  = !v2_reg || pipe.ld_p3;
    assign pipe.ld_p1  = !v1_reg || pipe.ld_p2;
    assign pipe.v_p5   = v5_reg;

    assign item_ready        = pipe.ld_p1;
    assign result_valid_next = v5_reg && p5_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            v5_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (pipe.ld_p1)
            begin
                v1_reg <= item_valid;
            end
            if (pipe.ld_p2)
            begin
                v2_reg <= v1_reg;
            end
            if (pipe.ld_p3)
            begin
                v3_reg <= v2_reg;
            end
            if (pipe.ld_p4)
            begin
                v4_reg <= v3_reg;
            end
            if (pipe.ld_p5)
            begin
                v5_reg <= v4_reg;
            end
            if (pipe.ld_out)
            begin
                result_valid_reg <= result_valid_next;
            end
        end
    end

    assign r2_full = rad1_reg * rad1_reg;
    assign r2_next = 64'(r2_full);

    always_ff @(posedge clk)
    begin
        if (pipe.ld_p1)
        begin
            op1_reg   <= op;
            last1_reg <= last;
            rad1_reg  <= radius;
        end
        if (pipe.ld_p2)
        begin
            op2_reg   <= op1_reg;
            last2_reg <= last1_reg;
            rad2_reg  <= rad1_reg;
            r2_reg    <= r2_next;
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        saot_lane #(
            .CW (COORD_WIDTH)
        ) u_lane (
            .clk  (clk),
            .pipe (pipe),
            .axis (axis_l[i]),
            .p    (p_l[i]),
            .q    (q_l[i]),
            .ap   (ap[i]),
            .aq   (aq[i]),
            .dd   (dd[i])
        );
    end

    saot_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .pipe    (pipe),
        .ap      (ap),
        .aq      (aq),
        .dd      (dd),
        .op      (op2_reg),
        .last    (last2_reg),
        .radius  (rad2_reg),
        .r2      (r2_reg),
        .p5_last (p5_last),
        .overlap (overlap)
    );

    assign result_valid = result_valid_reg;

    `SAOT_ASSERT(a_stall_only_when_full, !item_ready |-> (result_valid_reg && v1_reg && v2_reg && v3_reg && v4_reg && v5_reg), "item_ready low with a bubble in the pipeline")
    `SAOT_ASSERT(a_result_from_last, $rose(result_valid_reg) |-> $past(v5_reg && p5_last), "result raised without a final transaction in the last stage")
    `SAOT_ASSERT(a_accept_fills_stage, item_valid && item_ready |=> v1_reg, "accepted transaction missing from the first stage")
    `SAOT_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (!result_valid_reg && !v5_reg), "pipeline not empty after reset")

endmodule

// File: sim/overlap_checker.sv
// Checker for the separating-axis overlap test: watches both channels, predicts the
// overlap flag of every completed test and compares it with the block's results.
// Depends on saot_pkg for the value types, the operation codes and the radius format.
`timescale 1ns / 1ps

module overlap_checker
    import saot_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  logic [1:0]          op,
    input  logic [31:0]         axis_x,
    input  logic [31:0]         axis_y,
    input  logic [31:0]         axis_z,
    input  logic [31:0]         p_x,
    input  logic [31:0]         p_y,
    input  logic [31:0]         p_z,
    input  logic [31:0]         q_x,
    input  logic [31:0]         q_y,
    input  logic [31:0]         q_z,
    input  logic [RADIUS_W-1:0] radius,
    input  logic                last,
    input  logic                result_valid,
    input  logic                result_ready,
    input  logic                overlap,
    output int                  mismatches,
    output int                  outstanding
);

    localparam sval_t SVAL_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam sval_t SVAL_MIN = 64'sh8000_0000_0000_0000;

    logic  new_test;
    sval_t a_lo;
    sval_t a_hi;
    sval_t b_lo;
    sval_t b_hi;
    bit    overlap_due[$];
    int    fault_count;

    function automatic sval_t widen(input logic [31:0] c);
        sval_t v;
        v = {{32{c[31]}}, c};
        return v;
    endfunction

    function automatic sval_t clamp_sum(input sval_t a, input sval_t b);
        logic signed [64:0] wide;
        wide = a + b;
        if (wide > SVAL_MAX)
        begin
            return SVAL_MAX;
        end
        if (wide < SVAL_MIN)
        begin
            return SVAL_MIN;
        end
        return wide[63:0];
    endfunction

    function automatic sval_t project(input logic [0:2][31:0] dir, input logic [0:2][31:0] pt);
        sval_t acc;
        acc = widen(dir[0]) * widen(pt[0]);
        acc = clamp_sum(acc, widen(dir[1]) * widen(pt[1]));
        acc = clamp_sum(acc, widen(dir[2]) * widen(pt[2]));
        return acc;
    endfunction

    function automatic bit sphere_hit(input logic [0:2][31:0] ca, input logic [0:2][31:0] cb,
                                      input logic [RADIUS_W-1:0] rad);
        uval_t       dist2;
        uval_t       mag;
        uval_t       reach2;
        sval_t       delta;
        logic [64:0] total;
        int          i;
        dist2 = '0;
        for (i = 0; i < 3; i++)
        begin
            delta = widen(ca[i]) - widen(cb[i]);
            mag = delta[63] ? uval_t'(-delta) : uval_t'(delta);
            total = {1'b0, dist2} + {1'b0, mag * mag};
            dist2 = total[64] ? {64{1'b1}} : total[63:0];
        end
        reach2 = uval_t'(rad);
        reach2 = reach2 * reach2;
        return dist2 < reach2;
    endfunction

    function automatic bit absorb_item(input logic [1:0] code, input logic [0:2][31:0] dir,
                                       input logic [0:2][31:0] pa, input logic [0:2][31:0] pb,
                                       input logic [RADIUS_W-1:0] rad, input logic fin,
                                       output bit verdict);
        sval_t pp;
        sval_t qq;
        sval_t lo;
        sval_t hi;
        sval_t reach;
        verdict = 1'b0;
        if (code == OP_SPHERE_SPHERE)
        begin
            if (!fin)
            begin
                return 1'b0;
            end
            new_test = 1'b1;
            verdict = sphere_hit(pa, pb, rad);
            return 1'b1;
        end
        pp = project(dir, pa);
        qq = project(dir, pb);
        lo = pp;
        hi = pp;
        if (code == OP_SPHERE_BOX)
        begin
            reach = sval_t'(rad);
            reach = reach <<< RADIUS_SHIFT;
            lo = clamp_sum(pp, -reach);
            hi = clamp_sum(pp, reach);
        end
        if (new_test)
        begin
            a_lo = lo;
            a_hi = hi;
            b_lo = qq;
            b_hi = qq;
            new_test = 1'b0;
        end
        else
        begin
            if (lo < a_lo)
            begin
                a_lo = lo;
            end
            if (hi > a_hi)
            begin
                a_hi = hi;
            end
            if (qq < b_lo)
            begin
                b_lo = qq;
            end
            if (qq > b_hi)
            begin
                b_hi = qq;
            end
        end
        if (!fin)
        begin
            return 1'b0;
        end
        new_test = 1'b1;
        verdict = !(a_hi < b_lo || b_hi < a_lo);
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bit want;
        bit fresh;
        bit emits;
        if (!rst_n)
        begin
            new_test = 1'b1;
            a_lo = '0;
            a_hi = '0;
            b_lo = '0;
            b_hi = '0;
            overlap_due.delete();
            fault_count = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (overlap_due.size() == 0)
                begin
                    if (fault_count < 10)
                    begin
                        $display("%0t ns: result with nothing expected, overlap %b",
                                 $time, overlap);
                    end
                    fault_count++;
                end
                else
                begin
                    want = overlap_due.pop_front();
                    if (overlap !== want)
                    begin
                        if (fault_count < 10)
                        begin
                            $display("%0t ns: overlap expected %0b, got %b",
                                     $time, want, overlap);
                        end
                        fault_count++;
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                emits = absorb_item(op, {axis_x, axis_y, axis_z}, {p_x, p_y, p_z},
                                    {q_x, q_y, q_z}, radius, last, fresh);
                if (emits)
                begin
                    overlap_due.push_back(fresh);
                end
            end
            mismatches <= fault_count;
            outstanding <= overlap_due.size();
        end
    end

endmodule

// File: sim/sat_axis_overlap_test_test.sv
// Top of the overlap test bench: clock, reset, directed and random transactions on both
// channels and the final verdict. Depends on saot_pkg, the block itself and overlap_checker.
`timescale 1ns / 1ps

module sat_axis_overlap_test_test;
    import saot_pkg::*;

    localparam logic [1:0]          OP_BOX_BOX      = 2'd0;
    localparam logic [1:0]          OP_SELECT_THREE = 2'd3;
    localparam logic [31:0]         ZERO            = 32'h0000_0000;
    localparam logic [31:0]         UNIT            = 32'h0001_0000;
    localparam logic [31:0]         ONES            = 32'hffff_ffff;
    localparam logic [31:0]         CMAX            = 32'h7fff_ffff;
    localparam logic [31:0]         CMIN            = 32'h8000_0000;
    localparam logic [RADIUS_W-1:0] RMAX            = {RADIUS_W{1'b1}};
    localparam logic [RADIUS_W-1:0] R_UNIT          = RADIUS_W'(32'h1_0000);
    localparam int                  TOTAL_ITEMS     = 1050;
    localparam int                  BURST_ITEMS     = 60;
    localparam int                  HOLD_CYCLES     = 250;
    localparam int                  DRAIN_SLACK     = 20;
    localparam int                  CYCLE_LIMIT     = 600000;

    typedef struct packed {
        logic [1:0]          op;
        logic [0:2][31:0]    axis;
        logic [0:2][31:0]    p;
        logic [0:2][31:0]    q;
        logic [RADIUS_W-1:0] radius;
        logic                last;
    } sat_item_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    logic [1:0]          op = '0;
    logic signed [31:0]  axis_x = '0;
    logic signed [31:0]  axis_y = '0;
    logic signed [31:0]  axis_z = '0;
    logic signed [31:0]  p_x = '0;
    logic signed [31:0]  p_y = '0;
    logic signed [31:0]  p_z = '0;
    logic signed [31:0]  q_x = '0;
    logic signed [31:0]  q_y = '0;
    logic signed [31:0]  q_z = '0;
    logic [RADIUS_W-1:0] radius = '0;
    logic                last = 1'b0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic                overlap;
    int                  mismatches;
    int                  outstanding;
    int                  cycle_count = 0;
    int                  items_sent = 0;
    int                  hold_req = 0;
    logic                hold_active = 1'b0;
    bit                  no_gaps = 1'b0;

    sat_axis_overlap_test uut (.*);

    overlap_checker overlap_chk (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] extreme_value();
        case ($urandom_range(0, 4))
            0: return CMIN;
            1: return CMAX;
            2: return ZERO;
            3: return ONES;
            default: return UNIT;
        endcase
    endfunction

    function automatic logic [31:0] rand_coord(input int centre, input int spread);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            return extreme_value();
        end
        if (r < 25)
        begin
            return $urandom();
        end
        return centre + int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    function automatic logic [31:0] rand_axis();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            return extreme_value();
        end
        if (r < 25)
        begin
            return $urandom();
        end
        return int'($urandom_range(0, 2 ** 18)) - 2 ** 17;
    endfunction

    function automatic logic [RADIUS_W-1:0] rand_radius(input logic [1:0] code);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            return '0;
        end
        if (r < 6)
        begin
            return RMAX;
        end
        if (r < 25)
        begin
            return RADIUS_W'($urandom());
        end
        if (code == OP_SPHERE_SPHERE)
        begin
            return RADIUS_W'($urandom_range(0, 2 ** 14));
        end
        return RADIUS_W'($urandom_range(0, 2 ** 18));
    endfunction

    function automatic sat_item_t random_item(input logic [1:0] code, input int cp,
                                              input int cq, input logic fin);
        sat_item_t t;
        int        spread;
        int        i;
        spread = (code == OP_SPHERE_SPHERE) ? 2 ** 12 : 2 ** 15;
        t.op = code;
        t.last = fin;
        for (i = 0; i < 3; i++)
        begin
            t.axis[i] = rand_axis();
            t.p[i] = rand_coord(cp, spread);
            t.q[i] = rand_coord(cq, spread);
        end
        t.radius = rand_radius(code);
        return t;
    endfunction

    function automatic sat_item_t make_item(input logic [1:0] code,
                                            input logic [0:2][31:0] dir,
                                            input logic [0:2][31:0] pa,
                                            input logic [0:2][31:0] pb,
                                            input logic [RADIUS_W-1:0] rad,
                                            input logic fin);
        sat_item_t t;
        t.op = code;
        t.axis = dir;
        t.p = pa;
        t.q = pb;
        t.radius = rad;
        t.last = fin;
        return t;
    endfunction

    task automatic send_item(input sat_item_t t, input bit counted);
        int gap;
        int r;
        item_valid <= 1'b1;
        op <= t.op;
        axis_x <= t.axis[0];
        axis_y <= t.axis[1];
        axis_z <= t.axis[2];
        p_x <= t.p[0];
        p_y <= t.p[1];
        p_z <= t.p[2];
        q_x <= t.q[0];
        q_y <= t.q[1];
        q_z <= t.q[2];
        radius <= t.radius;
        last <= t.last;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        if (counted)
        begin
            items_sent++;
        end
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
        begin
            gap = 0;
        end
        else if (r < 85)
        begin
            gap = $urandom_range(1, 3);
        end
        else if (r < 96)
        begin
            gap = $urandom_range(4, 10);
        end
        else
        begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int served;
        int high_len;
        int low_len;
        int r;
        served = 0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_req != served)
            begin
                served++;
                result_ready <= 1'b0;
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active <= 1'b0;
            end
            high_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                   : $urandom_range(1, 10);
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                low_len = 0;
            end
            else if (r < 85)
            begin
                low_len = $urandom_range(1, 3);
            end
            else if (r < 97)
            begin
                low_len = $urandom_range(4, 10);
            end
            else
            begin
                low_len = $urandom_range(20, 50);
            end
            result_ready <= 1'b1;
            repeat (high_len) @(posedge clk);
            if (low_len > 0)
            begin
                result_ready <= 1'b0;
                repeat (low_len) @(posedge clk);
            end
        end
    end

    initial
    begin
        sat_item_t  t;
        int         pick;
        int         len;
        int         k;
        int         cp;
        int         cq;
        logic [1:0] code;
        logic [1:0] item_code;
        bit         mixed;
        bit         burst_done;
        burst_done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(make_item(OP_BOX_BOX, {UNIT, ZERO, ZERO}, {3{ZERO}}, {3{ZERO}}, '0, 1'b1),
                  1'b1);
        send_item(make_item(OP_BOX_BOX, {UNIT, ZERO, ZERO}, {UNIT, ZERO, ZERO},
                            {32'h0005_0000, ZERO, ZERO}, '0, 1'b0), 1'b1);
        send_item(make_item(OP_BOX_BOX, {UNIT, ZERO, ZERO}, {32'h0002_0000, ZERO, ZERO},
                            {32'h0003_0000, ZERO, ZERO}, '0, 1'b1), 1'b1);
        send_item(make_item(OP_BOX_BOX, {ZERO, UNIT, ZERO}, {ZERO, UNIT, ZERO},
                            {ZERO, 32'h0002_0000, ZERO}, '0, 1'b0), 1'b1);
        send_item(make_item(OP_BOX_BOX, {ZERO, UNIT, ZERO}, {ZERO, 32'h0002_0000, ZERO},
                            {ZERO, 32'h0003_0000, ZERO}, '0, 1'b1), 1'b1);
        send_item(make_item(OP_BOX_BOX, {3{CMIN}}, {3{CMIN}}, {3{CMAX}}, RMAX, 1'b1), 1'b1);
        send_item(make_item(OP_BOX_BOX, {3{CMAX}}, {3{CMAX}}, {3{CMAX}}, RMAX, 1'b1), 1'b1);
        send_item(make_item(OP_BOX_BOX, {3{ONES}}, {3{CMIN}}, {3{ONES}}, '0, 1'b1), 1'b1);
        send_item(make_item(OP_SPHERE_BOX, {3{CMIN}}, {3{CMIN}}, {3{ZERO}}, RMAX, 1'b1),
                  1'b1);
        send_item(make_item(OP_SPHERE_BOX, {3{CMIN}}, {3{CMAX}}, {3{CMIN}}, RMAX, 1'b1),
                  1'b1);
        send_item(make_item(OP_SPHERE_BOX, {UNIT, ZERO, ZERO}, {3{ZERO}}, {UNIT, ZERO, ZERO},
                            R_UNIT, 1'b1), 1'b1);
        send_item(make_item(OP_SPHERE_BOX, {UNIT, ZERO, ZERO}, {3{ZERO}}, {UNIT, ZERO, ZERO},
                            '0, 1'b1), 1'b1);
        send_item(make_item(OP_BOX_BOX, {3{UNIT}}, {3{ZERO}}, {3{UNIT}}, '0, 1'b0), 1'b1);
        send_item(make_item(OP_SPHERE_SPHERE, {3{CMAX}}, {3{CMIN}}, {3{CMAX}}, RMAX, 1'b0),
                  1'b0);
        send_item(make_item(OP_BOX_BOX, {3{UNIT}}, {3{UNIT}}, {3{32'h0002_0000}}, '0, 1'b1),
                  1'b1);
        send_item(make_item(OP_SPHERE_SPHERE, {3{ZERO}}, {32'd3, ZERO, ZERO},
                            {ZERO, 32'd4, ZERO}, 31'd5, 1'b1), 1'b1);
        send_item(make_item(OP_SPHERE_SPHERE, {3{ZERO}}, {32'd3, ZERO, ZERO},
                            {ZERO, 32'd4, ZERO}, 31'd6, 1'b1), 1'b1);
        send_item(make_item(OP_SPHERE_SPHERE, {3{ZERO}}, {3{CMAX}}, {3{CMIN}}, RMAX, 1'b1),
                  1'b1);
        send_item(make_item(OP_SPHERE_SPHERE, {3{ZERO}}, {3{CMIN}}, {3{CMIN}}, '0, 1'b1),
                  1'b1);
        send_item(make_item(OP_BOX_BOX, {UNIT, ZERO, ZERO}, {3{ZERO}}, {3{CMAX}}, '0, 1'b0),
                  1'b1);
        send_item(make_item(OP_SPHERE_SPHERE, {3{ZERO}}, {3{ZERO}}, {3{ZERO}}, RMAX, 1'b1),
                  1'b1);
        send_item(make_item(OP_BOX_BOX, {UNIT, ZERO, ZERO}, {3{UNIT}}, {3{UNIT}}, '0, 1'b1),
                  1'b1);
        send_item(make_item(OP_SELECT_THREE, {ZERO, ZERO, UNIT}, {3{CMIN}}, {3{ZERO}}, RMAX,
                            1'b0), 1'b1);
        send_item(make_item(OP_SELECT_THREE, {ZERO, ZERO, UNIT}, {3{ZERO}}, {3{CMAX}}, RMAX,
                            1'b1), 1'b1);
        drain_results();

        while (items_sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                no_gaps = !no_gaps;
            end
            cp = int'($urandom_range(0, 2 ** 18)) - 2 ** 17;
            cq = int'($urandom_range(0, 2 ** 18)) - 2 ** 17;
            if (!burst_done && items_sent >= 300)
            begin
                // Results are held back while transactions keep coming, so the pipeline fills.
                item_valid <= 1'b0;
                hold_req <= hold_req + 1;
                @(posedge clk);
                while (!hold_active)
                begin
                    @(posedge clk);
                end
                no_gaps = 1'b1;
                repeat (BURST_ITEMS)
                begin
                    send_item(random_item(OP_BOX_BOX, cp, cq, 1'b1), 1'b1);
                end
                no_gaps = 1'b0;
                drain_results();
                burst_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            mixed = 1'b0;
            if (pick < 35)
            begin
                code = OP_BOX_BOX;
            end
            else if (pick < 60)
            begin
                code = OP_SPHERE_BOX;
            end
            else if (pick < 80)
            begin
                code = OP_SPHERE_SPHERE;
            end
            else if (pick < 90)
            begin
                code = OP_SELECT_THREE;
            end
            else
            begin
                code = OP_BOX_BOX;
                mixed = 1'b1;
            end
            if (code == OP_SPHERE_SPHERE)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    send_item(random_item(OP_SPHERE_SPHERE, cp, cq, 1'b0), 1'b0);
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    send_item(random_item(OP_SPHERE_SPHERE, cp, cq, 1'b1), 1'b1);
                end
                else
                begin
                    send_item(random_item(OP_SPHERE_SPHERE, cp, cp, 1'b1), 1'b1);
                end
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    len = $urandom_range(1, 4);
                end
                else if (pick < 95)
                begin
                    len = $urandom_range(5, 12);
                end
                else
                begin
                    len = $urandom_range(13, 40);
                end
                for (k = 1; k <= len; k++)
                begin
                    item_code = mixed ? 2'($urandom_range(0, 3)) : code;
                    if (!mixed && $urandom_range(0, 19) == 0)
                    begin
                        send_item(random_item(OP_SPHERE_SPHERE, cp, cq, 1'b0), 1'b0);
                    end
                    t = random_item(item_code, cp, cq, k == len);
                    send_item(t, !(item_code == OP_SPHERE_SPHERE && !t.last));
                end
            end
            if ($urandom_range(0, 49) == 0)
            begin
                drain_results();
            end
        end

        drain_results();
        repeat (DRAIN_SLACK) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
